FILE: src/v3a_pkg.sv
// v3a_pkg: shared types and codes of the three-component vector ALU.
// No dependencies; imported by every module of the block except v3a_isqrt and v3a_div.
package v3a_pkg;

  // Raw operation codes as they arrive on the input channel.
  localparam logic [3:0] ACT_ADD   = 4'd0;
  localparam logic [3:0] ACT_SUB   = 4'd1;
  localparam logic [3:0] ACT_DOT   = 4'd2;
  localparam logic [3:0] ACT_SCALE = 4'd3;
  localparam logic [3:0] ACT_CROSS = 4'd4;
  localparam logic [3:0] ACT_NORM  = 4'd5;
  localparam logic [3:0] ACT_DIR   = 4'd6;
  localparam logic [3:0] ACT_DIST  = 4'd7;
  localparam logic [3:0] ACT_MAXAX = 4'd8;

  // Width of the integer square root of a sum of three squared magnitudes.
  localparam int ROOT_BITS = 36;

  typedef enum logic [3:0] {
    KIND_ADD, KIND_SUB, KIND_DOT, KIND_SCALE, KIND_CROSS,
    KIND_NORM, KIND_DIR, KIND_DIST, KIND_MAXAX, KIND_NONE
  } kind_t;

  // Classified request: sign-extended operands and the exact difference a-b.
  typedef struct packed {
    kind_t             kind;
    logic [2:0][32:0]  a;
    logic [2:0][32:0]  b;
    logic [2:0][32:0]  d;
    logic [32:0]       s;
  } item_t;

  typedef struct packed {
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_z;
    logic [31:0] sc;
    logic [1:0]  ax;
    logic        ov;
    logic        dz;
  } res_t;

endpackage

FILE: src/v3a_front.sv
// v3a_front: input register that sign-extends operands and classifies the opcode.
// Depends on v3a_pkg.
module v3a_front #(
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          in_action,
  input  logic [31:0]         in_a_x,
  input  logic [31:0]         in_a_y,
  input  logic [31:0]         in_a_z,
  input  logic [31:0]         in_b_x,
  input  logic [31:0]         in_b_y,
  input  logic [31:0]         in_b_z,
  input  logic [31:0]         in_scale_factor,
  output logic                q_valid,
  input  logic                q_ready,
  output v3a_pkg::item_t      q_item
);
  import v3a_pkg::*;

  localparam int EFF = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int SH  = 32 - EFF;

  logic  v_r;
  item_t item_r, item_nxt;

  function automatic logic [32:0] sext(logic [31:0] x);
    logic signed [31:0] t;
    t = $signed(x << SH) >>> SH;
    return 33'(t);
  endfunction

  always_comb begin
    logic [31:0] av [3];
    logic [31:0] bv [3];
    av[0] = in_a_x; av[1] = in_a_y; av[2] = in_a_z;
    bv[0] = in_b_x; bv[1] = in_b_y; bv[2] = in_b_z;
    unique case (in_action)
      ACT_ADD:   item_nxt.kind = KIND_ADD;
      ACT_SUB:   item_nxt.kind = KIND_SUB;
      ACT_DOT:   item_nxt.kind = KIND_DOT;
      ACT_SCALE: item_nxt.kind = KIND_SCALE;
      ACT_CROSS: item_nxt.kind = KIND_CROSS;
      ACT_NORM:  item_nxt.kind = KIND_NORM;
      ACT_DIR:   item_nxt.kind = KIND_DIR;
      ACT_DIST:  item_nxt.kind = KIND_DIST;
      ACT_MAXAX: item_nxt.kind = KIND_MAXAX;
      default:   item_nxt.kind = KIND_NONE;
    endcase
    for (int k = 0; k < 3; k++) begin
      item_nxt.a[k] = sext(av[k]);
      item_nxt.b[k] = sext(bv[k]);
      item_nxt.d[k] = 33'($signed(item_nxt.a[k]) - $signed(item_nxt.b[k]));
    end
    item_nxt.s = sext(in_scale_factor);
  end

  assign in_ready = !v_r || q_ready;
  assign q_valid  = v_r;
  assign q_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
      if (in_valid) item_r <= item_nxt;
    end
  end

endmodule

FILE: src/v3a_queue.sv
// v3a_queue: two-entry request queue between the front and the execution pipeline.
// Depends on v3a_pkg.
module v3a_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  v3a_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output v3a_pkg::item_t  pop_item
);
  import v3a_pkg::*;

  item_t      mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = mem_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wr_r] <= push_item;
        wr_r        <= !wr_r;
      end
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: src/v3a_isqrt.sv
// v3a_isqrt: pipelined integer square root, one result bit per stage.
// Standalone; carries an opaque tag alongside each radicand.
module v3a_isqrt #(
  parameter int RB    = 36,
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RB-1:0]   in_rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [RB-1:0]     out_root,
  output logic [TAG_W-1:0]  out_tag
);
  localparam int RW = 2 * RB + 1;

  logic             vld_r  [RB];
  logic [RW-1:0]    rem_r  [RB];
  logic [RB-1:0]    root_r [RB];
  logic [TAG_W-1:0] tag_r  [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stg
    localparam int I = RB - 1 - k;
    logic             v_i;
    logic [RW-1:0]    rem_i, trial;
    logic [RB-1:0]    root_i;
    logic [TAG_W-1:0] t_i;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = RW'(in_rad);
      assign root_i = '0;
      assign t_i    = in_tag;
    end else begin : g_next
      assign v_i    = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign t_i    = tag_r[k-1];
    end

    // (root + 2^I)^2 - root^2
    assign trial = (RW'(root_i) << (I + 1)) + (RW'(1'b1) << (2 * I));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_i;
        tag_r[k] <= t_i;
        if (rem_i >= trial) begin
          rem_r[k]  <= rem_i - trial;
          root_r[k] <= root_i | (RB'(1'b1) << I);
        end else begin
          rem_r[k]  <= rem_i;
          root_r[k] <= root_i;
        end
      end
    end
  end

  assign out_valid = vld_r[RB-1];
  assign out_root  = root_r[RB-1];
  assign out_tag   = tag_r[RB-1];

endmodule

FILE: src/v3a_div.sv
// v3a_div: three-lane pipelined restoring divider, one quotient bit per stage.
// Standalone; computes (num << (QB-1)) / den per lane, num <= den expected.
module v3a_div #(
  parameter int QB    = 17,
  parameter int MW    = 33,
  parameter int NW    = 36,
  parameter int TAG_W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][MW-1:0]   in_num,
  input  logic [NW-1:0]        in_den,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  output logic [2:0][QB-1:0]   out_quo,
  output logic [TAG_W-1:0]     out_tag
);
  localparam int RW = NW + 1;

  logic               vld_r [QB];
  logic [2:0][RW-1:0] rem_r [QB];
  logic [2:0][QB-1:0] quo_r [QB];
  logic [NW-1:0]      den_r [QB];
  logic [TAG_W-1:0]   tag_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stg
    localparam int J = QB - 1 - k;
    logic               v_i;
    logic [2:0][RW-1:0] rem_i, rem_nxt;
    logic [2:0][QB-1:0] quo_i, quo_nxt;
    logic [NW-1:0]      den_i;
    logic [TAG_W-1:0]   t_i;

    if (k == 0) begin : g_first
      assign v_i   = in_valid;
      assign den_i = in_den;
      assign t_i   = in_tag;
      assign quo_i = '0;
      for (genvar l = 0; l < 3; l++) begin : g_ln
        assign rem_i[l] = RW'(in_num[l]);
      end
    end else begin : g_next
      assign v_i   = vld_r[k-1];
      assign den_i = den_r[k-1];
      assign t_i   = tag_r[k-1];
      assign quo_i = quo_r[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_ln
        assign rem_i[l] = rem_r[k-1][l] << 1;
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        quo_nxt[l] = quo_i[l];
        if (rem_i[l] >= RW'(den_i)) begin
          rem_nxt[l]    = rem_i[l] - RW'(den_i);
          quo_nxt[l][J] = 1'b1;
        end else begin
          rem_nxt[l] = rem_i[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_i;
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        den_r[k] <= den_i;
        tag_r[k] <= t_i;
      end
    end
  end

  assign out_valid = vld_r[QB-1];
  assign out_quo   = quo_r[QB-1];
  assign out_tag   = tag_r[QB-1];

endmodule

FILE: src/v3a_back.sv
// v3a_back: execution pipeline (multiply, combine, saturate, root, divide, finish).
// Depends on v3a_pkg, v3a_isqrt and v3a_div.
module v3a_back #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  v3a_pkg::item_t  in_item,
  output logic            out_valid,
  output v3a_pkg::res_t   out_res
);
  import v3a_pkg::*;

  localparam int EFF = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int QB  = FRAC_BITS + 1;
  localparam logic signed [69:0] WMAX = (70'sd1 <<< (EFF - 1)) - 70'sd1;
  localparam logic signed [69:0] WMIN = -WMAX - 70'sd1;

  typedef struct packed {
    logic [31:0] v;
    logic        ov;
  } sat_t;

  typedef struct packed {
    kind_t            kind;
    logic [2:0][31:0] rv;
    logic [31:0]      sc;
    logic [1:0]       ax;
    logic             ov;
    logic [2:0][32:0] vm;
    logic [2:0]       vn;
  } tag_t;

  typedef struct packed {
    tag_t                 t;
    logic [ROOT_BITS-1:0] root;
  } mid_t;

  function automatic sat_t clampw(logic signed [69:0] x);
    sat_t r;
    r.v  = x[31:0];
    r.ov = 1'b0;
    if (x > WMAX) begin
      r.v  = WMAX[31:0];
      r.ov = 1'b1;
    end else if (x < WMIN) begin
      r.v  = WMIN[31:0];
      r.ov = 1'b1;
    end
    return r;
  endfunction

  function automatic sat_t satq(logic signed [69:0] x);
    logic signed [69:0] t;
    t = x >>> FRAC_BITS;
    return clampw(t);
  endfunction

  function automatic logic [32:0] mag33(logic [32:0] v);
    return v[32] ? (33'd0 - v) : v;
  endfunction

  // ---------------- stage 1: multipliers, add/sub, max axis
  logic                     s1_v_r;
  logic signed [67:0]       s1_p_r [6];
  logic signed [67:0]       p_nxt  [6];
  tag_t                     s1_tag_r, tag1_nxt;

  always_comb begin
    logic signed [32:0] av [3];
    logic signed [32:0] bv [3];
    logic signed [32:0] dv [3];
    logic signed [32:0] vv [3];
    logic signed [33:0] ma [6];
    logic signed [33:0] mb [6];
    logic signed [33:0] sum;
    sat_t               c;
    sum = '0;
    c   = '0;
    for (int k = 0; k < 3; k++) begin
      av[k] = $signed(in_item.a[k]);
      bv[k] = $signed(in_item.b[k]);
      dv[k] = $signed(in_item.d[k]);
      vv[k] = (in_item.kind == KIND_DIR || in_item.kind == KIND_DIST) ? dv[k] : av[k];
    end
    tag1_nxt      = '0;
    tag1_nxt.kind = in_item.kind;
    for (int k = 0; k < 3; k++) begin
      tag1_nxt.vm[k] = mag33(vv[k]);
      tag1_nxt.vn[k] = vv[k][32];
    end
    for (int j = 0; j < 6; j++) begin
      ma[j] = '0;
      mb[j] = '0;
    end
    unique case (in_item.kind)
      KIND_ADD: begin
        for (int k = 0; k < 3; k++) begin
          sum = 34'(av[k]) + 34'(bv[k]);
          c = clampw(70'(sum));
          tag1_nxt.rv[k] = c.v;
          tag1_nxt.ov    = tag1_nxt.ov | c.ov;
        end
      end
      KIND_SUB: begin
        for (int k = 0; k < 3; k++) begin
          c = clampw(70'(dv[k]));
          tag1_nxt.rv[k] = c.v;
          tag1_nxt.ov    = tag1_nxt.ov | c.ov;
        end
      end
      KIND_DOT: begin
        for (int k = 0; k < 3; k++) begin
          ma[k] = 34'(av[k]);
          mb[k] = 34'(bv[k]);
        end
      end
      KIND_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          ma[k] = 34'(av[k]);
          mb[k] = 34'($signed(in_item.s));
        end
      end
      KIND_CROSS: begin
        ma[0] = 34'(av[1]); mb[0] = 34'(bv[2]);
        ma[1] = 34'(av[2]); mb[1] = 34'(bv[1]);
        ma[2] = 34'(av[2]); mb[2] = 34'(bv[0]);
        ma[3] = 34'(av[0]); mb[3] = 34'(bv[2]);
        ma[4] = 34'(av[0]); mb[4] = 34'(bv[1]);
        ma[5] = 34'(av[1]); mb[5] = 34'(bv[0]);
      end
      KIND_NORM, KIND_DIR, KIND_DIST: begin
        for (int k = 0; k < 3; k++) begin
          ma[k] = $signed({1'b0, tag1_nxt.vm[k]});
          mb[k] = $signed({1'b0, tag1_nxt.vm[k]});
        end
      end
      KIND_MAXAX: begin
        // ties go to x, then y
        if (tag1_nxt.vm[0] >= tag1_nxt.vm[1] && tag1_nxt.vm[0] >= tag1_nxt.vm[2])
          tag1_nxt.ax = 2'd0;
        else if (tag1_nxt.vm[1] >= tag1_nxt.vm[2])
          tag1_nxt.ax = 2'd1;
        else
          tag1_nxt.ax = 2'd2;
      end
      default: ;
    endcase
    for (int j = 0; j < 6; j++) p_nxt[j] = ma[j] * mb[j];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r   <= in_valid;
      s1_tag_r <= tag1_nxt;
      for (int j = 0; j < 6; j++) s1_p_r[j] <= p_nxt[j];
    end
  end

  // ---------------- stage 2: sums and differences of products
  logic               s2_v_r;
  logic signed [69:0] s2_w_r [3];
  logic signed [69:0] w_nxt  [3];
  tag_t               s2_tag_r;

  always_comb begin
    unique case (s1_tag_r.kind)
      KIND_CROSS: begin
        w_nxt[0] = 70'(s1_p_r[0]) - 70'(s1_p_r[1]);
        w_nxt[1] = 70'(s1_p_r[2]) - 70'(s1_p_r[3]);
        w_nxt[2] = 70'(s1_p_r[4]) - 70'(s1_p_r[5]);
      end
      KIND_SCALE: begin
        for (int k = 0; k < 3; k++) w_nxt[k] = 70'(s1_p_r[k]);
      end
      default: begin
        w_nxt[0] = 70'(s1_p_r[0]) + 70'(s1_p_r[1]) + 70'(s1_p_r[2]);
        w_nxt[1] = '0;
        w_nxt[2] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r   <= s1_v_r;
      s2_tag_r <= s1_tag_r;
      for (int k = 0; k < 3; k++) s2_w_r[k] <= w_nxt[k];
    end
  end

  // ---------------- stage 3: rescale and saturate, pick radicand
  logic                     s3_v_r;
  logic [2*ROOT_BITS-1:0]   s3_rad_r, rad_nxt;
  tag_t                     s3_tag_r, tag3_nxt;

  always_comb begin
    sat_t c;
    c        = '0;
    tag3_nxt = s2_tag_r;
    rad_nxt  = '0;
    unique case (s2_tag_r.kind)
      KIND_DOT: begin
        c = satq(s2_w_r[0]);
        tag3_nxt.sc = c.v;
        tag3_nxt.ov = c.ov;
      end
      KIND_SCALE, KIND_CROSS: begin
        for (int k = 0; k < 3; k++) begin
          c = satq(s2_w_r[k]);
          tag3_nxt.rv[k] = c.v;
          tag3_nxt.ov    = tag3_nxt.ov | c.ov;
        end
      end
      KIND_NORM, KIND_DIR, KIND_DIST: begin
        rad_nxt = (2*ROOT_BITS)'(s2_w_r[0][67:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r   <= s2_v_r;
      s3_tag_r <= tag3_nxt;
      s3_rad_r <= rad_nxt;
    end
  end

  // ---------------- square root and divide
  logic                 sq_v;
  logic [ROOT_BITS-1:0] sq_root;
  tag_t                 sq_tag;
  mid_t                 div_tag_in, div_tag_out;
  logic                 dv_v;
  logic [2:0][QB-1:0]   dv_q;

  v3a_isqrt #(.RB(ROOT_BITS), .TAG_W($bits(tag_t))) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s3_v_r),
    .in_rad    (s3_rad_r),
    .in_tag    (s3_tag_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  assign div_tag_in.t    = sq_tag;
  assign div_tag_in.root = sq_root;

  v3a_div #(.QB(QB), .MW(33), .NW(ROOT_BITS), .TAG_W($bits(mid_t))) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sq_v),
    .in_num    (sq_tag.vm),
    .in_den    (sq_root),
    .in_tag    (div_tag_in),
    .out_valid (dv_v),
    .out_quo   (dv_q),
    .out_tag   (div_tag_out)
  );

  // ---------------- finish: signs, clamp, flags
  always_comb begin
    sat_t               c;
    logic signed [69:0] qs;
    logic [2:0][31:0]   rv;
    c          = '0;
    qs         = '0;
    rv         = div_tag_out.t.rv;
    out_res.sc = div_tag_out.t.sc;
    out_res.ax = div_tag_out.t.ax;
    out_res.ov = div_tag_out.t.ov;
    out_res.dz = 1'b0;
    unique case (div_tag_out.t.kind)
      KIND_NORM, KIND_DIR: begin
        if (div_tag_out.root == '0) begin
          out_res.dz = 1'b1;
          rv         = '0;
        end else begin
          for (int k = 0; k < 3; k++) begin
            qs = 70'(dv_q[k]);
            if (div_tag_out.t.vn[k]) qs = -qs;
            c = clampw(qs);
            rv[k]      = c.v;
            out_res.ov = out_res.ov | c.ov;
          end
        end
      end
      KIND_DIST: begin
        c = clampw(70'(div_tag_out.root));
        out_res.sc = c.v;
        out_res.ov = c.ov;
      end
      default: ;
    endcase
    out_res.r_x = rv[0];
    out_res.r_y = rv[1];
    out_res.r_z = rv[2];
  end

  assign out_valid = dv_v;

endmodule

FILE: src/vector3_alu_unit.sv
// vector3_alu_unit: top level of the three-component fixed-point vector ALU.
// Depends on v3a_pkg, v3a_front, v3a_queue and v3a_back.
//
// Each request carries an opcode, two signed fixed-point vectors a and b and a
// scale, and produces exactly one result in request order: add, subtract, dot,
// scale, cross, normalize a, unit direction from b to a, distance, or index of
// the largest magnitude component (ties to x, then y). Out-of-range results
// saturate and raise overflow; normalizing a zero-length vector returns zeros
// with divide_zero set; unknown opcodes return all zeros. The block sustains
// one request per clock while the output is not stalled: every operation flows
// through the same fixed pipeline of a front register, a two-entry queue,
// multiply / combine / saturate stages, a 36-stage one-bit-per-stage square
// root, a FRAC_BITS+1 stage three-lane divider and the output register. A
// stall on out_ready holds the whole execution pipeline; the queue and front
// register keep taking up to three more requests before in_ready drops.
module vector3_alu_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_action,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_scale_factor,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_r_x,
  output logic signed [31:0] out_r_y,
  output logic signed [31:0] out_r_z,
  output logic signed [31:0] out_scalar_out,
  output logic [1:0]         out_axis,
  output logic               out_overflow,
  output logic               out_divide_zero
);
  import v3a_pkg::*;

  logic  fq_valid, fq_ready;
  item_t fq_item;
  logic  qb_valid;
  item_t qb_item;
  logic  bk_valid;
  res_t  bk_res;
  logic  adv;
  logic  out_valid_r;
  res_t  out_res_r;

  // Front: register the request, sign-extend, classify the opcode.
  v3a_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_a_x          (in_a_x),
    .in_a_y          (in_a_y),
    .in_a_z          (in_a_z),
    .in_b_x          (in_b_x),
    .in_b_y          (in_b_y),
    .in_b_z          (in_b_z),
    .in_scale_factor (in_scale_factor),
    .q_valid         (fq_valid),
    .q_ready         (fq_ready),
    .q_item          (fq_item)
  );

  // Queue decouples the front from pipeline stalls.
  v3a_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (adv),
    .pop_item   (qb_item)
  );

  // Advance the whole execution pipeline whenever the output register is free
  // or being drained this cycle; otherwise hold every stage, bubbles included.
  assign adv = !out_valid_r || out_ready;

  v3a_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (qb_valid),
    .in_item   (qb_item),
    .out_valid (bk_valid),
    .out_res   (bk_res)
  );

  // Output register: holds a finished result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= bk_valid;
      if (bk_valid) out_res_r <= bk_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_r_x         = $signed(out_res_r.r_x);
  assign out_r_y         = $signed(out_res_r.r_y);
  assign out_r_z         = $signed(out_res_r.r_z);
  assign out_scalar_out  = $signed(out_res_r.sc);
  assign out_axis        = out_res_r.ax;
  assign out_overflow    = out_res_r.ov;
  assign out_divide_zero = out_res_r.dz;

  // A nonzero axis only comes from max axis, which carries no vector or scalar.
  a_axis_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_axis != 2'd0 |->
      out_r_x == 32'sd0 && out_r_y == 32'sd0 && out_r_z == 32'sd0 &&
      out_scalar_out == 32'sd0)
    else $error("axis reported together with vector or scalar data");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_axis != 2'd3)
    else $error("axis index out of range");

  // A zero-length normalize never saturates and leaves the vector at zero.
  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_zero |->
      !out_overflow && out_r_x == 32'sd0 && out_r_y == 32'sd0 && out_r_z == 32'sd0)
    else $error("divide_zero result is not clean");

  // The pipeline only moves a result into a full output register when it drains.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(out_res_r))
    else $error("output register changed while stalled");

endmodule

FILE: tb/sv/vector3_alu_unit_tb.sv
// vector3_alu_unit_tb: self-checking testbench of the three-component vector ALU.
// Depends on v3a_pkg and vector3_alu_unit. The scoreboard predicts each result
// from the accepted request and compares it with the output channel in order.
module vector3_alu_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import v3a_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 43;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [3:0]  action;
    logic [31:0] ax, ay, az, bx, by, bz, sf;
  } vec_req_t;

  typedef struct {
    logic [31:0] rx, ry, rz, sc;
    logic [1:0]  axis;
    logic        ov, dz;
  } vec_res_t;

  // Predict results of the vector ALU and hold them in request order.
  class vec_scoreboard;
    vec_res_t pending[$];
    int       errors;

    function void clamp(input logic signed [127:0] v, output logic [31:0] r,
                        inout logic ov);
      if (v > 128'sd2147483647) begin
        r = 32'h7fffffff; ov = 1'b1;
      end else if (v < -128'sd2147483648) begin
        r = 32'h80000000; ov = 1'b1;
      end else begin
        r = v[31:0];
      end
    endfunction

    // Arithmetic shift by the fraction width floors toward minus infinity.
    function void sat_frac(input logic signed [127:0] v, output logic [31:0] r,
                           inout logic ov);
      clamp(v >>> FRAC, r, ov);
    endfunction

    function logic [63:0] root_len(input logic signed [127:0] d[3]);
      logic [127:0] acc, c;
      logic [63:0]  r;
      acc = 0;
      r = 0;
      for (int i = 0; i < 3; i++) begin
        c = (d[i] < 0) ? -d[i] : d[i];
        acc += c * c;
      end
      for (int i = 35; i >= 0; i--) begin
        c = {64'd0, r | (64'd1 << i)};
        if (c * c <= acc) r = c[63:0];
      end
      return r;
    endfunction

    function void unit_vec(input logic signed [127:0] d[3], inout vec_res_t e);
      logic [63:0]  n;
      logic [127:0] m, q;
      logic [31:0]  r[3];
      n = root_len(d);
      if (n == 0) begin
        e.dz = 1'b1;
        return;
      end
      for (int i = 0; i < 3; i++) begin
        m = (d[i] < 0) ? -d[i] : d[i];
        q = (m << FRAC) / n;
        clamp((d[i] < 0) ? -$signed(q) : $signed(q), r[i], e.ov);
      end
      e.rx = r[0]; e.ry = r[1]; e.rz = r[2];
    endfunction

    function void note_request(input vec_req_t q);
      logic signed [127:0] a[3], b[3], d[3], s, m[3];
      vec_res_t e;
      e = '{default: '0};
      a[0] = $signed(q.ax); a[1] = $signed(q.ay); a[2] = $signed(q.az);
      b[0] = $signed(q.bx); b[1] = $signed(q.by); b[2] = $signed(q.bz);
      s = $signed(q.sf);
      for (int i = 0; i < 3; i++) d[i] = a[i] - b[i];
      case (q.action)
        ACT_ADD: begin
          clamp(a[0] + b[0], e.rx, e.ov);
          clamp(a[1] + b[1], e.ry, e.ov);
          clamp(a[2] + b[2], e.rz, e.ov);
        end
        ACT_SUB: begin
          clamp(d[0], e.rx, e.ov);
          clamp(d[1], e.ry, e.ov);
          clamp(d[2], e.rz, e.ov);
        end
        ACT_DOT: sat_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], e.sc, e.ov);
        ACT_SCALE: begin
          sat_frac(a[0] * s, e.rx, e.ov);
          sat_frac(a[1] * s, e.ry, e.ov);
          sat_frac(a[2] * s, e.rz, e.ov);
        end
        ACT_CROSS: begin
          sat_frac(a[1] * b[2] - a[2] * b[1], e.rx, e.ov);
          sat_frac(a[2] * b[0] - a[0] * b[2], e.ry, e.ov);
          sat_frac(a[0] * b[1] - a[1] * b[0], e.rz, e.ov);
        end
        ACT_NORM: unit_vec(a, e);
        ACT_DIR:  unit_vec(d, e);
        ACT_DIST: clamp($signed({64'd0, root_len(d)}), e.sc, e.ov);
        ACT_MAXAX: begin
          for (int i = 0; i < 3; i++) m[i] = (a[i] < 0) ? -a[i] : a[i];
          if (m[0] >= m[1] && m[0] >= m[2]) e.axis = 2'd0;
          else if (m[1] >= m[2]) e.axis = 2'd1;
          else e.axis = 2'd2;
        end
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(input vec_res_t got);
      vec_res_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.rx !== e.rx) begin
        $error("r_x expected %h actual %h", e.rx, got.rx); errors++;
      end
      if (got.ry !== e.ry) begin
        $error("r_y expected %h actual %h", e.ry, got.ry); errors++;
      end
      if (got.rz !== e.rz) begin
        $error("r_z expected %h actual %h", e.rz, got.rz); errors++;
      end
      if (got.sc !== e.sc) begin
        $error("scalar_out expected %h actual %h", e.sc, got.sc); errors++;
      end
      if (got.axis !== e.axis) begin
        $error("axis expected %0d actual %0d", e.axis, got.axis); errors++;
      end
      if (got.ov !== e.ov) begin
        $error("overflow expected %b actual %b", e.ov, got.ov); errors++;
      end
      if (got.dz !== e.dz) begin
        $error("divide_zero expected %b actual %b", e.dz, got.dz); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [3:0] in_action;
  logic signed [31:0] in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_scale_factor;
  logic signed [31:0] out_r_x, out_r_y, out_r_z, out_scalar_out;
  logic [1:0] out_axis;
  logic out_overflow, out_divide_zero;

  vector3_alu_unit uut (.*);

  vec_scoreboard board;
  vec_req_t      drive_req;
  int            idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note each accepted request at the edge it is taken, and check each result.
  always @(posedge clk) begin
    vec_res_t got;
    if (rst_n && in_valid && in_ready) board.note_request(drive_req);
    if (rst_n && out_valid && out_ready) begin
      got.rx = out_r_x; got.ry = out_r_y; got.rz = out_r_z;
      got.sc = out_scalar_out; got.axis = out_axis;
      got.ov = out_overflow; got.dz = out_divide_zero;
      board.check_result(got);
    end
  end

  // Watchdog: count cycles without any handshake; reset clears the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("vector3_alu_unit_tb failed");
        $finish;
      end
    end
  end

  // Receiver stalls on its own pattern: quiet stretches, then random backpressure.
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      mode = ($urandom_range(0, 199) < 2) ? $urandom_range(0, 2) : mode;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
      4: return $signed($urandom_range(0, 2 ** 20)) - (2 ** 19);
      default: return $urandom();
    endcase
  endfunction

  // Present one request and hold it until accepted.
  task automatic send(input vec_req_t q);
    drive_req <= q;
    in_valid <= 1'b1;
    in_action <= q.action;
    in_a_x <= q.ax; in_a_y <= q.ay; in_a_z <= q.az;
    in_b_x <= q.bx; in_b_y <= q.by; in_b_z <= q.bz;
    in_scale_factor <= q.sf;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_vec(input logic [3:0] act, input logic [31:0] ax, ay, az,
                          bx, by, bz, sf);
    vec_req_t q;
    q = '{act, ax, ay, az, bx, by, bz, sf};
    send(q);
  endtask

  initial begin
    vec_req_t q;
    int burst, waited;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = '0;
    {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_scale_factor} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every opcode at the extremes, zero-length cases, axis ties, unused codes.
    for (int op = 0; op <= 8; op++)
      send_vec(4'(op), 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send_vec(ACT_NORM, 0, 0, 0, 1, 2, 3, 0);
    send_vec(ACT_DIR, 5, -7, 9, 5, -7, 9, 0);
    send_vec(ACT_DIST, 5, 5, 5, 5, 5, 5, 0);
    send_vec(ACT_NORM, 32'h00010000, 0, 0, 0, 0, 0, 0);
    send_vec(ACT_DIR, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    send_vec(ACT_MAXAX, 7, -7, 7, 0, 0, 0, 0);
    send_vec(ACT_MAXAX, 1, -7, 7, 0, 0, 0, 0);
    send_vec(ACT_MAXAX, 1, 2, 32'h80000000, 0, 0, 0, 0);
    send_vec(ACT_SCALE, 32'hffffffff, 32'h1, 32'h00018000, 0, 0, 0, 32'hffffffff);
    send_vec(ACT_CROSS, 1, 2, 3, 4, 5, 6, 0);
    send_vec(4'd9, 1, 2, 3, 4, 5, 6, 7);
    send_vec(4'd15, -1, -1, -1, -1, -1, -1, -1);

    // Random: bursts of requests, mostly separated by random gaps.
    for (int n = 0; n < 1200; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++, n++) begin
        q.action = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
        q.ax = rand_word(); q.ay = rand_word(); q.az = rand_word();
        if ($urandom_range(0, 9) == 0) begin
          q.bx = q.ax; q.by = q.ay; q.bz = q.az;
        end else begin
          q.bx = rand_word(); q.by = rand_word(); q.bz = rand_word();
        end
        q.sf = rand_word();
        send(q);
      end
      if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    // Drain the scoreboard, then keep the clock running to catch any stray result.
    while (board.pending.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < 2 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    if (board.errors == 0) $display("vector3_alu_unit_tb passed");
    else $display("vector3_alu_unit_tb failed");
    $finish;
  end
endmodule
